// File: src/lzpu_pkg.sv
// Package for the page unpacker: item types, the command passed from the
// token decoder to the executer, and shared constants. No dependencies.
`default_nettype none

package lzpu_pkg;

	// One compressed byte as it arrives.
	typedef struct packed {
		logic [7:0] src_byte;
		logic       last_byte;
	} in_item_t;

	// One result of up to four decoded bytes.
	typedef struct packed {
		logic [7:0] out_byte_0;
		logic [7:0] out_byte_1;
		logic [7:0] out_byte_2;
		logic [7:0] out_byte_3;
		logic [2:0] byte_count;
		logic       run_last;
		logic       page_done;
		logic       decode_error;
	} out_item_t;

	// Token form, taken from the two low bits of the first header byte.
	localparam logic [1:0] TOK_RUN   = 2'd0;
	localparam logic [1:0] TOK_SHORT = 2'd1;
	localparam logic [1:0] TOK_MATCH = 2'd2;
	localparam logic [1:0] TOK_LONG  = 2'd3;

	// Kind of run that follows the optional literal byte of a command.
	localparam logic [1:0] RUN_NONE  = 2'd0;
	localparam logic [1:0] RUN_FILL  = 2'd1;
	localparam logic [1:0] RUN_MATCH = 2'd2;

	// Work that one input item causes, as seen by the executer.
	typedef struct packed {
		logic        lit_valid;
		logic [7:0]  lit_byte;
		logic [1:0]  run_kind;
		logic [7:0]  run_len;
		logic [7:0]  run_byte;
		logic [11:0] copy_dist;
		logic        last;
		logic        done;
		logic        err;
		logic        force_result;
	} cmd_t;

	localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// File: src/lzpu_if.sv
// Valid/ready channels for compressed input items and decoded result items.
// Depends on lzpu_pkg.
`default_nettype none

interface lzpu_feed_if;
	logic               valid;
	logic               ready;
	lzpu_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface lzpu_result_if;
	logic                valid;
	logic                ready;
	lzpu_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/lz_page_unpacker.sv
// Page unpacker top level. The token decoder turns each item into a command;
// the executer then loads the command, writes each literal or fill byte, reads
// and then writes the history RAM for each copied byte, and flushes.
// The executer takes a new command only once it is through with the last one.
// Reset clears all control state; the history RAM is not cleared.
// Depends on lzpu_pkg, lzpu_if, lzpu_front, lzpu_queue and lzpu_back.
`default_nettype none

module lz_page_unpacker #(
	parameter int MAX_PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [12:0] cfg_wdata,
	lzpu_feed_if.sink        feed,
	lzpu_result_if.source    result
);
	import lzpu_pkg::*;

	logic [12:0] page_size_q;
	cmd_t        push_cmd, head_cmd;
	logic        push, full, head_valid, pop;

	// Page size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q <= 13'd4096;
		end else if (cfg_we) begin
			page_size_q <= cfg_wdata;
		end
	end

	lzpu_front #(.MAX_PAGE_BYTES(MAX_PAGE_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.feed      (feed),
		.page_size (page_size_q),
		.q_full    (full),
		.cmd_push  (push),
		.cmd       (push_cmd)
	);

	lzpu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (full),
		.pop    (pop),
		.valid  (head_valid),
		.dout   (head_cmd)
	);

	lzpu_back #(.MAX_PAGE_BYTES(MAX_PAGE_BYTES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (head_valid),
		.q_data  (head_cmd),
		.q_pop   (pop),
		.result  (result)
	);
endmodule

`default_nettype wire

// File: src/lzpu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module lzpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

// File: src/lzpu_front.sv
// Token decoder: accepts compressed items, tracks token state, checks bounds
// and turns each item into one command. Depends on lzpu_pkg and lzpu_if.
`default_nettype none

module lzpu_front #(
	parameter int MAX_PAGE_BYTES = 4096
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	lzpu_feed_if.sink   feed,
	input  wire logic [12:0] page_size,
	input  wire logic   q_full,
	output logic        cmd_push,
	output lzpu_pkg::cmd_t cmd
);
	import lzpu_pkg::*;

	localparam int PW = $clog2(MAX_PAGE_BYTES + 1);
	localparam int CW = (PW > 13) ? PW : 13;

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_THIRD  = 2'd2;

	logic [CW-1:0] pos_q, pos_d;
	logic [7:0]    tb0_q, tb0_d, tb1_q, tb1_d;
	logic [1:0]    ph_q, ph_d;
	logic [5:0]    lit_q, lit_d, pend_q, pend_d;
	logic [11:0]   pdist_q, pdist_d;
	logic          err_q, err_d, full_q, full_d;
	logic          accept;

	assign feed.ready = !q_full;
	assign accept     = feed.valid && !q_full;
	assign cmd_push   = accept;

	// Decode one byte against the current token state.
	always_comb begin
		logic [CW-1:0] eff, rem, grow;
		logic [CW:0]   reach;
		logic [7:0]    b;
		logic          full0, full1, active;
		logic          st_en;
		logic [3:0]    st_lit;
		logic [5:0]    st_len;
		logic [11:0]   st_dist;

		b   = feed.payload.src_byte;
		eff = (CW'(page_size) > CW'(MAX_PAGE_BYTES)) ? CW'(MAX_PAGE_BYTES) : CW'(page_size);
		rem = eff - pos_q;
		full0  = full_q || (pos_q >= eff);
		active = !full0 && !err_q;
		reach  = '0;

		pos_d   = pos_q;
		tb0_d   = tb0_q;
		tb1_d   = tb1_q;
		ph_d    = ph_q;
		lit_d   = lit_q;
		pend_d  = pend_q;
		pdist_d = pdist_q;
		err_d   = err_q;
		st_en   = 1'b0;
		st_lit  = '0;
		st_len  = '0;
		st_dist = '0;
		cmd     = '0;

		if (active) begin
			if (lit_q != '0) begin
				// Literal byte of a running token, then its match at the end.
				cmd.lit_valid = 1'b1;
				cmd.lit_byte  = b;
				lit_d = lit_q - 6'd1;
				if (lit_q == 6'd1) begin
					if (pend_q != '0) begin
						cmd.run_kind  = RUN_MATCH;
						cmd.run_len   = {2'b00, pend_q};
						cmd.copy_dist = pdist_q;
					end
					pend_d = '0;
				end
			end else begin
				unique case (ph_q)
					PH_START: begin
						tb0_d = b;
						if (b[1:0] == TOK_RUN && b != 8'd0) begin
							st_en  = 1'b1;
							st_len = '0;
							st_lit = 4'd0;
							// A pure literal run can be up to 63 long.
						end else begin
							ph_d = PH_SECOND;
						end
					end
					PH_SECOND: begin
						tb1_d = b;
						case (tb0_q[1:0])
							TOK_RUN: begin
								if (b == 8'd0) begin
									ph_d = PH_START;
								end else if (CW'(b) > rem) begin
									err_d  = 1'b1;
									ph_d   = PH_START;
									lit_d  = '0;
									pend_d = '0;
								end else begin
									ph_d = PH_THIRD;
								end
							end
							TOK_SHORT: begin
								st_en   = 1'b1;
								st_lit  = {2'b00, tb0_q[3:2]};
								st_len  = {3'b000, tb0_q[6:4]} + 6'd3;
								st_dist = {3'b000, b, tb0_q[7]};
							end
							TOK_MATCH: begin
								st_en   = 1'b1;
								st_len  = {4'b0000, tb0_q[3:2]} + 6'd3;
								st_dist = {b, tb0_q[7:4]};
							end
							default: begin
								ph_d = PH_THIRD;
							end
						endcase
					end
					default: begin
						if (tb0_q[1:0] == TOK_RUN) begin
							// Fill run of the count byte times this byte.
							ph_d         = PH_START;
							cmd.run_kind = RUN_FILL;
							cmd.run_len  = tb1_q;
							cmd.run_byte = b;
						end else begin
							st_en   = 1'b1;
							st_lit  = tb0_q[5:2];
							st_len  = {tb1_q[3:0], tb0_q[7:6]};
							st_dist = {b, tb1_q[7:4]};
						end
					end
				endcase
			end
		end

		// Token start: bounds check, then either literals or an immediate match.
		if (st_en) begin
			ph_d  = PH_START;
			reach = {1'b0, pos_q} + (CW + 1)'(st_lit);
			if (tb0_q[1:0] == TOK_RUN && ph_q == PH_START) begin
				st_lit = 4'd0;
			end
			if (ph_q == PH_START) begin
				// Plain literal run: length is the upper six bits of the byte.
				if (CW'(b[7:2]) > rem) begin
					err_d  = 1'b1;
					lit_d  = '0;
					pend_d = '0;
				end else begin
					lit_d  = b[7:2];
					pend_d = '0;
				end
			end else if ((CW'(st_lit) + CW'(st_len)) > rem ||
					reach < (CW + 1)'(st_dist)) begin
				err_d  = 1'b1;
				lit_d  = '0;
				pend_d = '0;
			end else begin
				lit_d   = {2'b00, st_lit};
				pend_d  = st_len;
				pdist_d = st_dist;
				if (st_lit == 4'd0) begin
					pend_d = '0;
					if (st_len != '0) begin
						cmd.run_kind  = RUN_MATCH;
						cmd.run_len   = {2'b00, st_len};
						cmd.copy_dist = st_dist;
					end
				end
			end
		end

		grow  = CW'(cmd.lit_valid) + ((cmd.run_kind != RUN_NONE) ? CW'(cmd.run_len) : '0);
		pos_d = pos_q + grow;
		full1 = full0 || (pos_d >= eff);

		// A page that ends inside a token is flagged as a decode error.
		if (feed.payload.last_byte && !full1 && !err_d &&
				(ph_d != PH_START || lit_d != '0)) begin
			err_d = 1'b1;
		end

		full_d            = full1;
		cmd.last          = feed.payload.last_byte;
		cmd.done          = feed.payload.last_byte || full1;
		cmd.err           = err_d;
		cmd.force_result  = feed.payload.last_byte || (err_d && !err_q);
	end

	// Token state; a last item returns everything to the page start.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tb0_q   <= '0;
			tb1_q   <= '0;
			ph_q    <= PH_START;
			lit_q   <= '0;
			pend_q  <= '0;
			pdist_q <= '0;
			err_q   <= 1'b0;
			full_q  <= 1'b0;
		end else if (accept) begin
			if (feed.payload.last_byte) begin
				pos_q   <= '0;
				tb0_q   <= '0;
				tb1_q   <= '0;
				ph_q    <= PH_START;
				lit_q   <= '0;
				pend_q  <= '0;
				pdist_q <= '0;
				err_q   <= 1'b0;
				full_q  <= 1'b0;
			end else begin
				pos_q   <= pos_d;
				tb0_q   <= tb0_d;
				tb1_q   <= tb1_d;
				ph_q    <= ph_d;
				lit_q   <= lit_d;
				pend_q  <= pend_d;
				pdist_q <= pdist_d;
				err_q   <= err_d;
				full_q  <= full_d;
			end
		end
	end
endmodule

`default_nettype wire

// File: src/lzpu_queue.sv
// Short command queue between the token decoder and the executer.
// Depends on lzpu_pkg.
`default_nettype none

module lzpu_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  lzpu_pkg::cmd_t      din,
	output logic                full,
	input  wire logic           pop,
	output logic                valid,
	output lzpu_pkg::cmd_t      dout
);
	import lzpu_pkg::*;

	localparam int PTRW = $clog2(QUEUE_DEPTH);
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [PTRW-1:0] wr_q, rd_q;
	logic [CNTW-1:0] cnt_q;

	assign full  = (cnt_q == CNTW'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign dout  = slot_q[rd_q];

	// Storage is written only on push.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTRW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTRW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end
endmodule

`default_nettype wire

// File: src/lzpu_back.sv
// Executer: carries out commands, writes the page history, copies matches
// and packs bytes into results. Depends on lzpu_pkg, lzpu_if and lzpu_ram.
`default_nettype none

module lzpu_back #(
	parameter int MAX_PAGE_BYTES = 4096
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_valid,
	input  lzpu_pkg::cmd_t q_data,
	output logic           q_pop,
	lzpu_result_if.source  result
);
	import lzpu_pkg::*;

	localparam int PW = $clog2(MAX_PAGE_BYTES + 1);
	localparam int CW = (PW > 13) ? PW : 13;
	localparam int AW = $clog2(MAX_PAGE_BYTES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LIT   = 3'd1;
	localparam logic [2:0] ST_FILL  = 3'd2;
	localparam logic [2:0] ST_RD    = 3'd3;
	localparam logic [2:0] ST_WR    = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]    state_q, state_d;
	cmd_t          cmd_q, cmd_d;
	logic [7:0]    len_q, len_d;
	logic [CW-1:0] wpos_q, wpos_d;
	logic [7:0]    pk_q [4];
	logic [7:0]    pk_d [4];
	logic [2:0]    pk_cnt_q, pk_cnt_d;
	out_item_t     out_q, out_d;
	logic          out_valid_q, out_valid_d;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic [CW-1:0] src_pos;

	assign result.valid   = out_valid_q;
	assign result.payload = out_q;
	assign src_pos        = wpos_q - CW'(cmd_q.copy_dist);

	lzpu_ram #(.WIDTH(8), .DEPTH(MAX_PAGE_BYTES)) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer and byte packer.
	always_comb begin
		logic       can_push, put_en, put_ok;
		logic [7:0] put_byte;

		can_push = !out_valid_q || result.ready;
		state_d  = state_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		wpos_d   = wpos_q;
		pk_d     = pk_q;
		pk_cnt_d = pk_cnt_q;
		out_d    = out_q;
		out_valid_d = out_valid_q && !result.ready;
		q_pop    = 1'b0;
		re       = 1'b0;
		raddr    = src_pos[AW-1:0];
		put_en   = 1'b0;
		put_byte = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					cmd_d = q_data;
					len_d = q_data.run_len;
					if (q_data.lit_valid) begin
						state_d = ST_LIT;
					end else if (q_data.run_kind == RUN_FILL && q_data.run_len != '0) begin
						state_d = ST_FILL;
					end else if (q_data.run_kind == RUN_MATCH && q_data.run_len != '0) begin
						state_d = ST_RD;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_LIT: begin
				put_en   = 1'b1;
				put_byte = cmd_q.lit_byte;
			end
			ST_FILL: begin
				put_en   = 1'b1;
				put_byte = cmd_q.run_byte;
			end
			ST_RD: begin
				re      = 1'b1;
				state_d = ST_WR;
			end
			ST_WR: begin
				put_en   = 1'b1;
				put_byte = (cmd_q.copy_dist == '0) ? 8'd0 : rdata;
			end
			ST_FLUSH: begin
				if (pk_cnt_q != '0 || cmd_q.force_result) begin
					if (can_push) begin
						out_valid_d        = 1'b1;
						out_d.out_byte_0   = (pk_cnt_q > 3'd0) ? pk_q[0] : 8'd0;
						out_d.out_byte_1   = (pk_cnt_q > 3'd1) ? pk_q[1] : 8'd0;
						out_d.out_byte_2   = (pk_cnt_q > 3'd2) ? pk_q[2] : 8'd0;
						out_d.out_byte_3   = (pk_cnt_q > 3'd3) ? pk_q[3] : 8'd0;
						out_d.byte_count   = pk_cnt_q;
						out_d.run_last     = 1'b1;
						out_d.page_done    = cmd_q.done;
						out_d.decode_error = cmd_q.err;
						pk_cnt_d = '0;
						state_d  = ST_IDLE;
						if (cmd_q.last) begin
							wpos_d = '0;
						end
					end
				end else begin
					state_d = ST_IDLE;
					if (cmd_q.last) begin
						wpos_d = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// A full packer must hand its group on before the next byte enters.
		put_ok = (pk_cnt_q != 3'd4) || can_push;
		we     = put_en && put_ok;
		waddr  = wpos_q[AW-1:0];
		wdata  = put_byte;
		if (put_en && put_ok) begin
			wpos_d = wpos_q + CW'(1);
			if (pk_cnt_q == 3'd4) begin
				out_valid_d        = 1'b1;
				out_d.out_byte_0   = pk_q[0];
				out_d.out_byte_1   = pk_q[1];
				out_d.out_byte_2   = pk_q[2];
				out_d.out_byte_3   = pk_q[3];
				out_d.byte_count   = 3'd4;
				out_d.run_last     = 1'b0;
				out_d.page_done    = 1'b0;
				out_d.decode_error = cmd_q.err;
				pk_d[0]  = put_byte;
				pk_cnt_d = 3'd1;
			end else begin
				pk_d[pk_cnt_q[1:0]] = put_byte;
				pk_cnt_d = pk_cnt_q + 3'd1;
			end
			if (state_q == ST_LIT) begin
				if (cmd_q.run_kind == RUN_FILL && cmd_q.run_len != '0) begin
					state_d = ST_FILL;
				end else if (cmd_q.run_kind == RUN_MATCH && cmd_q.run_len != '0) begin
					state_d = ST_RD;
				end else begin
					state_d = ST_FLUSH;
				end
			end else begin
				len_d = len_q - 8'd1;
				if (len_q == 8'd1) begin
					state_d = ST_FLUSH;
				end else if (state_q == ST_WR) begin
					state_d = ST_RD;
				end
			end
		end
	end

	// Control and payload registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			len_q       <= '0;
			wpos_q      <= '0;
			pk_q        <= '{default: 8'd0};
			pk_cnt_q    <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cmd_q       <= cmd_d;
			len_q       <= len_d;
			wpos_q      <= wpos_d;
			pk_q        <= pk_d;
			pk_cnt_q    <= pk_cnt_d;
			out_q       <= out_d;
			out_valid_q <= out_valid_d;
		end
	end

	// A copy write always follows its own history read.
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> ($past(state_q) == ST_RD || $past(state_q) == ST_WR))
		else $error("copy write without a preceding read");

	// The packer never holds more than one group.
	a_pk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pk_cnt_q <= 3'd4)
		else $error("packer count out of range");

	// A history read never reaches before the page start.
	a_rd_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		(re && cmd_q.copy_dist != '0) |-> (CW'(cmd_q.copy_dist) <= wpos_q))
		else $error("history read before page start");
endmodule

`default_nettype wire
